### hw/rtl/dmsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmsp_pkg;

  localparam int SPEED_W   = 15;
  localparam int ERR_W     = 16;
  localparam int DERR_W    = 17;
  localparam int INTEG_W   = 22;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 20;
  localparam int THR_W     = 15;
  localparam int DUTY_W    = 16;
  localparam int TERM_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;
  localparam int NUM_CH    = 2;

  localparam logic [GAIN_W-1:0]  KP_RESET  = 16'd28160;
  localparam logic [GAIN_W-1:0]  KI_RESET  = 16'd204;
  localparam logic [GAIN_W-1:0]  KD_RESET  = 16'd5120;
  localparam logic [LIMIT_W-1:0] LIM_RESET = 20'd10000;
  localparam logic [THR_W-1:0]   THR_RESET = 15'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_LEFT  = 3'd0,
    REG_KI_LEFT  = 3'd1,
    REG_KD_LEFT  = 3'd2,
    REG_KP_RIGHT = 3'd3,
    REG_KI_RIGHT = 3'd4,
    REG_KD_RIGHT = 3'd5,
    REG_INT_LIM  = 3'd6,
    REG_SEP_THR  = 3'd7
  } reg_idx_t;

  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    gains_t             left;
    gains_t             right;
    logic [LIMIT_W-1:0] integral_limit;
    logic [THR_W-1:0]   sep_thr;
  } cfg_t;

  typedef struct packed {
    logic signed [INTEG_W-1:0] integ;
    logic signed [ERR_W-1:0]   prev_err;
  } ch_state_t;

endpackage

`default_nettype wire

### hw/rtl/dmsp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module dmsp_cfg
  import dmsp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KP_LEFT:  cfg_nxt.left.kp         = cfg_wdata[GAIN_W-1:0];
        REG_KI_LEFT:  cfg_nxt.left.ki         = cfg_wdata[GAIN_W-1:0];
        REG_KD_LEFT:  cfg_nxt.left.kd         = cfg_wdata[GAIN_W-1:0];
        REG_KP_RIGHT: cfg_nxt.right.kp        = cfg_wdata[GAIN_W-1:0];
        REG_KI_RIGHT: cfg_nxt.right.ki        = cfg_wdata[GAIN_W-1:0];
        REG_KD_RIGHT: cfg_nxt.right.kd        = cfg_wdata[GAIN_W-1:0];
        REG_INT_LIM:  cfg_nxt.integral_limit  = cfg_wdata[LIMIT_W-1:0];
        REG_SEP_THR:  cfg_nxt.sep_thr         = cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left.kp        <= KP_RESET;
      cfg_r.left.ki        <= KI_RESET;
      cfg_r.left.kd        <= KD_RESET;
      cfg_r.right.kp       <= KP_RESET;
      cfg_r.right.ki       <= KI_RESET;
      cfg_r.right.kd       <= KD_RESET;
      cfg_r.integral_limit <= LIM_RESET;
      cfg_r.sep_thr        <= THR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### hw/rtl/dmsp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dmsp_datapath
  import dmsp_pkg::*;
#(
  parameter int DUTY_LIMIT = 9000
) (
  input  wire logic signed [SPEED_W-1:0] target_speed,
  input  wire logic signed [SPEED_W-1:0] measured_speed,
  input  wire gains_t                    gains,
  input  wire logic [LIMIT_W-1:0]        integral_limit,
  input  wire logic [THR_W-1:0]          sep_thr,
  input  wire ch_state_t                 state_cur,
  output ch_state_t                      state_nxt,
  output logic signed [DUTY_W-1:0]       duty
);

  localparam logic signed [TERM_W-1:0] SAT_POS = TERM_W'(DUTY_LIMIT);
  localparam logic signed [TERM_W-1:0] SAT_NEG = -SAT_POS;

  logic signed [ERR_W-1:0]     err;
  logic [ERR_W-1:0]            err_mag;
  logic signed [INTEG_W:0]     sum_raw;
  logic signed [INTEG_W:0]     lim_pos;
  logic signed [INTEG_W:0]     lim_neg;
  logic signed [INTEG_W-1:0]   sum_clamp;
  logic [INTEG_W-1:0]          sum_mag;
  logic signed [DERR_W-1:0]    derr;
  logic [DERR_W-1:0]           derr_mag;
  logic [ERR_W+GAIN_W-1:0]     p_prod;
  logic [INTEG_W+GAIN_W-1:0]   i_prod;
  logic [DERR_W+GAIN_W-1:0]    d_prod;
  logic signed [TERM_W-1:0]    p_term;
  logic signed [TERM_W-1:0]    i_term;
  logic signed [TERM_W-1:0]    d_term;
  logic signed [TERM_W-1:0]    total;

  always_comb begin
    err     = ERR_W'(target_speed) - ERR_W'(measured_speed);
    err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    sum_raw = (INTEG_W+1)'(state_cur.integ) + (INTEG_W+1)'(err);
    lim_pos = $signed({3'b000, integral_limit});
    lim_neg = -lim_pos;
    if (sum_raw > lim_pos) begin
      sum_clamp = lim_pos[INTEG_W-1:0];
    end else if (sum_raw < lim_neg) begin
      sum_clamp = lim_neg[INTEG_W-1:0];
    end else begin
      sum_clamp = sum_raw[INTEG_W-1:0];
    end
    sum_mag = sum_clamp[INTEG_W-1] ? INTEG_W'(-sum_clamp) : INTEG_W'(sum_clamp);

    derr     = DERR_W'(err) - DERR_W'(state_cur.prev_err);
    derr_mag = derr[DERR_W-1] ? DERR_W'(-derr) : DERR_W'(derr);

    p_prod = (ERR_W+GAIN_W)'(err_mag) * (ERR_W+GAIN_W)'(gains.kp);
    i_prod = (INTEG_W+GAIN_W)'(sum_mag) * (INTEG_W+GAIN_W)'(gains.ki);
    d_prod = (DERR_W+GAIN_W)'(derr_mag) * (DERR_W+GAIN_W)'(gains.kd);

    p_term = $signed(TERM_W'(p_prod >> 8));
    if (err[ERR_W-1]) p_term = -p_term;

    i_term = $signed(TERM_W'(i_prod >> 8));
    if (sum_clamp[INTEG_W-1]) i_term = -i_term;
    if (err_mag > ERR_W'(sep_thr)) i_term = '0;

    d_term = $signed(TERM_W'(d_prod >> 8));
    if (derr[DERR_W-1]) d_term = -d_term;

    total = p_term + i_term + d_term;
    if (total >= SAT_POS) begin
      duty = SAT_POS[DUTY_W-1:0];
    end else if (total <= SAT_NEG) begin
      duty = SAT_NEG[DUTY_W-1:0];
    end else begin
      duty = total[DUTY_W-1:0];
    end

    state_nxt.integ    = sum_clamp;
    state_nxt.prev_err = err;
  end

endmodule

`default_nettype wire

### hw/rtl/dual_motor_speed_pid_unit.sv
// An accepted transaction moves from the input register to the output register.
// Throughput: one transaction per cycle while the output is not stalled; the input
// register feeds the combinational PID arithmetic, which writes the output register
// and the per-channel state. Back-pressure stalls the output stage and a full input stage.
// Reset (synchronous, active low) clears both stages, the integral sums and the
// previous errors, and restores the gain, limit and threshold registers.
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_speed_pid_unit
  import dmsp_pkg::*;
#(
  parameter int DUTY_LIMIT = 9000
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [31:0]          in_tdata,   // target_speed[14:0], measured_speed[29:15]
  input  wire logic                 in_tuser,   // channel select (0 = left, 1 = right)
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [15:0]               out_tdata,  // duty[15:0]
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  cfg_t                        cfg;
  gains_t                      gains;
  ch_state_t                   state_r [NUM_CH];
  ch_state_t                   state_cur;
  ch_state_t                   state_nxt;
  logic                        in_vld_r;
  logic                        in_ch_r;
  logic signed [SPEED_W-1:0]   in_tgt_r;
  logic signed [SPEED_W-1:0]   in_meas_r;
  logic                        out_vld_r;
  logic signed [DUTY_W-1:0]    out_duty_r;
  logic signed [DUTY_W-1:0]    duty_nxt;
  logic                        advance;

  dmsp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign gains     = (in_ch_r == CH_RIGHT) ? cfg.right : cfg.left;
  assign state_cur = state_r[in_ch_r];

  dmsp_datapath #(
    .DUTY_LIMIT (DUTY_LIMIT)
  ) u_datapath (
    .target_speed   (in_tgt_r),
    .measured_speed (in_meas_r),
    .gains          (gains),
    .integral_limit (cfg.integral_limit),
    .sep_thr        (cfg.sep_thr),
    .state_cur      (state_cur),
    .state_nxt      (state_nxt),
    .duty           (duty_nxt)
  );

  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      state_r[0] <= '0;
      state_r[1] <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          state_r[in_ch_r] <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_ch_r   <= in_tuser;
      in_tgt_r  <= in_tdata[SPEED_W-1:0];
      in_meas_r <= in_tdata[2*SPEED_W-1:SPEED_W];
    end
    if (advance && in_vld_r) begin
      out_duty_r <= duty_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_duty_r;

  a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= DUTY_W'(DUTY_LIMIT)) &&
                   ($signed(out_tdata) >= -$signed(DUTY_W'(DUTY_LIMIT))))
    else $error("duty outside the saturation limit");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_vld_r && out_vld_r && !out_tready)
    else $error("input stalled with room in the pipeline");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_tready |=> in_vld_r && $stable(in_tgt_r) &&
                                             $stable(in_meas_r) && $stable(in_ch_r))
    else $error("stalled input stage lost its transaction");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && advance |=> out_vld_r)
    else $error("transaction in the input stage did not reach the output");

endmodule

`default_nettype wire
